// ===== sv/ckrt_pkg.sv =====
// ----------------------------------------------------------------------------
// ckrt_pkg
// Shared types and codes of the compacting keyed record table.
// ----------------------------------------------------------------------------
package ckrt_pkg;

  localparam int unsigned PlateW = 56;
  localparam int unsigned OwnerW = 32;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_LIST     = 2'd1,
    CMD_RM_PLATE = 2'd2,
    CMD_RM_ID    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // classified command, as held between front and back
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LIST   = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_APPEND = 3'd1,
    CELL_MATCH  = 3'd2,
    CELL_REMOVE = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_op_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [PlateW-1:0]        plate_key;
    logic signed [OwnerW-1:0] owner_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [PlateW-1:0]        out_plate;
    logic signed [OwnerW-1:0] out_owner;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    op_e                      op;
    logic                     by_id;
    logic [PlateW-1:0]        plate;
    logic signed [OwnerW-1:0] owner;
  } front_item_t;

  typedef struct packed {
    cell_op_e op;
    logic     by_id;
  } cell_ctl_t;

endpackage

// ===== sv/ckrt_fifo.sv =====
// ----------------------------------------------------------------------------
// ckrt_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ckrt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/ckrt_front.sv =====
// ----------------------------------------------------------------------------
// ckrt_front
// Accepts command items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ckrt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ckrt_pkg::in_item_t    item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output ckrt_pkg::front_item_t item_o,
  output logic                  empty_o
);

  localparam int unsigned FW = $bits(ckrt_pkg::front_item_t);

  ckrt_pkg::front_item_t cls;
  logic [FW-1:0]         q_rdata;

  always_comb begin
    cls.plate = item_i.plate_key;
    cls.owner = item_i.owner_id;
    cls.by_id = (item_i.cmd == ckrt_pkg::CMD_RM_ID);
    unique case (item_i.cmd) inside
      ckrt_pkg::CMD_INSERT:                      cls.op = ckrt_pkg::OP_INSERT;
      ckrt_pkg::CMD_LIST:                        cls.op = ckrt_pkg::OP_LIST;
      ckrt_pkg::CMD_RM_PLATE, ckrt_pkg::CMD_RM_ID: cls.op = ckrt_pkg::OP_REMOVE;
      default:                                   cls.op = ckrt_pkg::OP_LIST;
    endcase
  end

  ckrt_fifo #(
    .WIDTH(FW),
    .DEPTH(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(cls),
    .full_o (full_o),
    .pop_i  (pop_i),
    .rdata_o(q_rdata),
    .empty_o(empty_o)
  );

  assign item_o = ckrt_pkg::front_item_t'(q_rdata);

endmodule

// ===== sv/ckrt_cells.sv =====
// ----------------------------------------------------------------------------
// ckrt_cells
// Row of record cells: parallel key compare, gap closing shift, tail append
// and a rotate that brings each record to cell 0 in turn for listing.
// ----------------------------------------------------------------------------
module ckrt_cells #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ckrt_pkg::cell_ctl_t                   ctl_i,
  input  logic [CW-1:0]                         count_i,
  input  logic [ckrt_pkg::PlateW-1:0]           plate_i,
  input  logic signed [ckrt_pkg::OwnerW-1:0]    owner_i,
  output logic                                  any_hit_o,
  output logic [ckrt_pkg::PlateW-1:0]           head_plate_o,
  output logic signed [ckrt_pkg::OwnerW-1:0]    head_owner_o
);

  localparam logic [DEPTH-1:0] AllOnes = '1;

  logic [ckrt_pkg::PlateW-1:0]        plate_q [DEPTH];
  logic [ckrt_pkg::PlateW-1:0]        plate_d [DEPTH];
  logic [ckrt_pkg::PlateW-1:0]        up_plate [DEPTH];
  logic signed [ckrt_pkg::OwnerW-1:0] owner_q [DEPTH];
  logic signed [ckrt_pkg::OwnerW-1:0] owner_d [DEPTH];
  logic signed [ckrt_pkg::OwnerW-1:0] up_owner [DEPTH];
  logic [DEPTH-1:0]                   match_q, match_d;
  logic [DEPTH-1:0]                   shift_v;

  // neighbor above each cell; the top cell wraps to cell 0 for rotation
  for (genvar g = 0; g < DEPTH; g++) begin : g_up
    if (g < DEPTH - 1) begin : g_mid
      assign up_plate[g] = plate_q[g+1];
      assign up_owner[g] = owner_q[g+1];
    end else begin : g_top
      assign up_plate[g] = plate_q[0];
      assign up_owner[g] = owner_q[0];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (CW'(i) < count_i) &&
                   (ctl_i.by_id ? (owner_q[i] == owner_i) : (plate_q[i] == plate_i));
    end
  end

  // every cell at or above the first hit takes its upper neighbor
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      shift_v[i] = |(match_q & (AllOnes >> (DEPTH - 1 - i)));
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      plate_d[i] = plate_q[i];
      owner_d[i] = owner_q[i];
      case (ctl_i.op)
        ckrt_pkg::CELL_APPEND: begin
          if (count_i == CW'(i)) begin
            plate_d[i] = plate_i;
            owner_d[i] = owner_i;
          end
        end
        ckrt_pkg::CELL_REMOVE: begin
          if (shift_v[i]) begin
            plate_d[i] = up_plate[i];
            owner_d[i] = up_owner[i];
          end
        end
        ckrt_pkg::CELL_ROTATE: begin
          if (count_i == CW'(i + 1)) begin
            plate_d[i] = plate_q[0];
            owner_d[i] = owner_q[0];
          end else begin
            plate_d[i] = up_plate[i];
            owner_d[i] = up_owner[i];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      plate_q[i] <= plate_d[i];
      owner_q[i] <= owner_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
    end else if (ctl_i.op == ckrt_pkg::CELL_MATCH) begin
      match_q <= match_d;
    end
  end

  assign any_hit_o    = |match_q;
  assign head_plate_o = plate_q[0];
  assign head_owner_o = owner_q[0];

endmodule

// ===== sv/ckrt_back.sv =====
// ----------------------------------------------------------------------------
// ckrt_back
// Command sequencer: runs queued commands on the cell row and writes
// result items into the result queue.
// ----------------------------------------------------------------------------
module ckrt_back #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_empty_i,
  input  ckrt_pkg::front_item_t              cmd_i,
  output logic                               cmd_pop_o,
  output ckrt_pkg::cell_ctl_t                cell_ctl_o,
  input  logic                               any_hit_i,
  input  logic [ckrt_pkg::PlateW-1:0]        head_plate_i,
  input  logic signed [ckrt_pkg::OwnerW-1:0] head_owner_i,
  output logic [CW-1:0]                      count_o,
  input  logic                               res_full_i,
  output logic                               res_push_o,
  output ckrt_pkg::out_item_t                res_item_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REMOVE = 2'd1;
  localparam logic [1:0] S_LIST   = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          list_last;

  assign list_last = ((idx_q + CW'(1)) == count_q);

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    idx_d            = idx_q;
    cmd_pop_o        = 1'b0;
    cell_ctl_o.op    = ckrt_pkg::CELL_HOLD;
    cell_ctl_o.by_id = cmd_i.by_id;
    res_push_o       = 1'b0;
    res_item_o       = '0;
    res_item_o.last  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            ckrt_pkg::OP_INSERT: begin
              res_push_o = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                res_item_o.status = ckrt_pkg::ST_FULL;
              end else begin
                cell_ctl_o.op     = ckrt_pkg::CELL_APPEND;
                count_d           = count_q + CW'(1);
                res_item_o.status = ckrt_pkg::ST_DONE;
              end
            end
            ckrt_pkg::OP_LIST: begin
              if (count_q == '0) begin
                res_push_o        = 1'b1;
                res_item_o.status = ckrt_pkg::ST_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = S_LIST;
              end
            end
            ckrt_pkg::OP_REMOVE: begin
              cell_ctl_o.op = ckrt_pkg::CELL_MATCH;
              state_d       = S_REMOVE;
            end
            default: ;
          endcase
        end
      end
      S_REMOVE: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
          if (any_hit_i) begin
            cell_ctl_o.op     = ckrt_pkg::CELL_REMOVE;
            count_d           = count_q - CW'(1);
            res_item_o.status = ckrt_pkg::ST_DONE;
          end else begin
            res_item_o.status = ckrt_pkg::ST_NOTFOUND;
          end
        end
      end
      S_LIST: begin
        // cell 0 is emitted, then the row rotates by one record
        if (!res_full_i) begin
          res_push_o           = 1'b1;
          res_item_o.status    = ckrt_pkg::ST_ENTRY;
          res_item_o.out_plate = head_plate_i;
          res_item_o.out_owner = head_owner_i;
          res_item_o.last      = list_last;
          cell_ctl_o.op        = ckrt_pkg::CELL_ROTATE;
          idx_d                = idx_q + CW'(1);
          if (list_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  assign count_o = count_q;

endmodule

// ===== sv/compacting_keyed_record_table_top.sv =====
// ----------------------------------------------------------------------------
// compacting_keyed_record_table_top
// Ordered table of plate/owner records with append, list and keyed remove.
// ----------------------------------------------------------------------------
// Commands enter on a queue-style port: an item is taken when push is high
// and full is low. Results leave on a second queue: the oldest result sits
// on res_item_o while empty is low and is taken when pop is high.
// A command item goes through a two-entry command queue into the sequencer;
// results go through a two-entry result queue, so the receiver can stall
// without blocking new commands until both queues fill.
// Insert and list of an empty table are answered when the sequencer takes
// them; a remove first compares all cells and registers the hits, then
// closes the gap and answers; a list emits its first row from the list state.
// Throughput: insert one item per cycle; a remove holds the sequencer until
// it answers; list one row per cycle (the cell row rotates one place per
// row); all bounded by the sequencer and stalled while the result queue is full.
// Reset empties the table and both queues; no clearing pass is needed.
// A stalled receiver holds the sequencer while the result queue is full.
// ----------------------------------------------------------------------------
module compacting_keyed_record_table_top #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  ckrt_pkg::in_item_t  in_item_i,
  output logic                full,
  input  logic                pop,
  output ckrt_pkg::out_item_t res_item_o,
  output logic                empty
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned OW = $bits(ckrt_pkg::out_item_t);

  ckrt_pkg::front_item_t              cmd;
  logic                               cmd_empty;
  logic                               cmd_pop;
  ckrt_pkg::cell_ctl_t                cell_ctl;
  logic                               any_hit;
  logic [ckrt_pkg::PlateW-1:0]        head_plate;
  logic signed [ckrt_pkg::OwnerW-1:0] head_owner;
  logic [CW-1:0]                      count;
  logic                               res_full;
  logic                               res_push;
  ckrt_pkg::out_item_t                res_item;
  logic [OW-1:0]                      res_rdata;

  ckrt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_item_i),
    .full_o (full),
    .pop_i  (cmd_pop),
    .item_o (cmd),
    .empty_o(cmd_empty)
  );

  ckrt_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cell_ctl_o  (cell_ctl),
    .any_hit_i   (any_hit),
    .head_plate_i(head_plate),
    .head_owner_i(head_owner),
    .count_o     (count),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_item_o  (res_item)
  );

  ckrt_cells #(
    .DEPTH(DEPTH)
  ) u_cells (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (cell_ctl),
    .count_i     (count),
    .plate_i     (cmd.plate),
    .owner_i     (cmd.owner),
    .any_hit_o   (any_hit),
    .head_plate_o(head_plate),
    .head_owner_o(head_owner)
  );

  ckrt_fifo #(
    .WIDTH(OW),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_item),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign res_item_o = ckrt_pkg::out_item_t'(res_rdata);

  // table occupancy stays within bounds
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(DEPTH))
    else $error("record count above table depth");

  // occupancy moves by at most one record per cycle
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count == $past(count) || count == $past(count) + CW'(1) ||
              count == $past(count) - CW'(1)))
    else $error("record count jumped");

  // only listed rows may be non-final, and only they carry a record
  a_row_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_item_o.status != ckrt_pkg::ST_ENTRY) |->
      (res_item_o.last && res_item_o.out_plate == '0 && res_item_o.out_owner == '0))
    else $error("non-list result with payload or without last");

endmodule
